[design/cdtb_pkg.sv]
`default_nettype none

package cdtb_pkg;

    localparam int ACT_W  = 2;
    localparam int BANK_W = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int SUB_W  = 10;
    localparam int TPS_W  = 11;

    localparam logic [TPS_W-1:0] TPS_RESET = 11'd1000;
    localparam logic [TPS_W-1:0] TPS_MAX   = 11'd1024;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // bank codes
    localparam logic [BANK_W-1:0] BANK_MS    = 2'd0;
    localparam logic [BANK_W-1:0] BANK_SEC   = 2'd1;
    localparam logic [BANK_W-1:0] BANK_DELAY = 2'd2;

    // command walking down the cell chain, picking up read data on the way
    typedef struct packed {
        logic              valid;
        logic [ACT_W-1:0]  action;
        logic [BANK_W-1:0] bank;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  load;
        logic [VAL_W-1:0]  rdata;
    } cmd_t;

endpackage

`default_nettype wire

[design/cdtb_cell.sv]
`default_nettype none

// one timer slot of each bank large enough to hold it; applies the passing command and hands it on
module cdtb_cell #(
    parameter int CELL_IDX  = 0,
    parameter bit HAS_MS    = 1'b1,
    parameter bit HAS_SEC   = 1'b1,
    parameter bit HAS_DELAY = 1'b1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [cdtb_pkg::TPS_W-1:0] limit,
    input  wire cdtb_pkg::cmd_t             cmd_in,
    output cdtb_pkg::cmd_t                  cmd_out
);

    logic [cdtb_pkg::VAL_W-1:0] ms_reg, ms_next;
    logic [cdtb_pkg::VAL_W-1:0] sec_reg, sec_next;
    logic [cdtb_pkg::SUB_W-1:0] sub_reg, sub_next;
    logic [cdtb_pkg::VAL_W-1:0] delay_reg, delay_next;
    cdtb_pkg::cmd_t             cmd_reg, cmd_next;

    logic [cdtb_pkg::TPS_W-1:0] sub_inc;
    logic                       hit;

    assign sub_inc = {1'b0, sub_reg} + 11'd1;
    assign hit     = (int'(cmd_in.idx) == CELL_IDX);

    always_comb
    begin
        ms_next    = ms_reg;
        sec_next   = sec_reg;
        sub_next   = sub_reg;
        delay_next = delay_reg;
        cmd_next   = cmd_in;
        if (cmd_in.valid)
        begin
            unique case (cmd_in.action)
                cdtb_pkg::ACT_TICK:
                begin
                    if (HAS_MS && (ms_reg != '0))
                        ms_next = ms_reg - 16'd1;
                    if (HAS_DELAY && (delay_reg != '0))
                        delay_next = delay_reg - 16'd1;
                    // second timer zero never ticks
                    if (HAS_SEC && (CELL_IDX != 0) && (sec_reg != '0))
                    begin
                        if (sub_inc >= limit)
                        begin
                            sub_next = '0;
                            sec_next = sec_reg - 16'd1;
                        end
                        else
                            sub_next = sub_inc[cdtb_pkg::SUB_W-1:0];
                    end
                end
                cdtb_pkg::ACT_WRITE:
                begin
                    if (hit)
                    begin
                        unique case (cmd_in.bank)
                            cdtb_pkg::BANK_MS:    if (HAS_MS) ms_next = cmd_in.load;
                            cdtb_pkg::BANK_SEC:   if (HAS_SEC) sec_next = cmd_in.load;
                            cdtb_pkg::BANK_DELAY: if (HAS_DELAY) delay_next = cmd_in.load;
                            default: ;
                        endcase
                    end
                end
                cdtb_pkg::ACT_READ:
                begin
                    if (hit)
                    begin
                        unique case (cmd_in.bank)
                            cdtb_pkg::BANK_MS:    if (HAS_MS) cmd_next.rdata = ms_reg;
                            cdtb_pkg::BANK_SEC:   if (HAS_SEC) cmd_next.rdata = sec_reg;
                            cdtb_pkg::BANK_DELAY: if (HAS_DELAY) cmd_next.rdata = delay_reg;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg    <= '0;
            sec_reg   <= '0;
            sub_reg   <= '0;
            delay_reg <= '0;
            cmd_reg   <= '0;
        end
        else if (advance)
        begin
            ms_reg    <= ms_next;
            sec_reg   <= sec_next;
            sub_reg   <= sub_next;
            delay_reg <= delay_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign cmd_out = cmd_reg;

endmodule

`default_nettype wire

[design/countdown_timer_bank.sv]
// channel | direction | payload (low bit first)                        | item accepted on
// s_*     | in        | tuser: action, bank; tdata: timer_index, load   | s_tvalid & s_tready
// m_*     | out       | tdata: read_value                                | m_tvalid & m_tready
// cfg_*   | in        | cfg_data: ticks_per_second                       | cfg_valid & cfg_ready
//
// an item walks a chain of CHAIN_LEN cells (largest bank size), one cell per cycle while
// the chain is not held; m_tvalid rises when its result is registered from the chain end
// and s_tready returns with it, so a new item is taken only once the last one has left the chain
// rst_n clears every timer and sub-counter at once and loads ticks_per_second with 1000
// a result left waiting in the output register does not stop acceptance; the chain
// freezes only when a second result reaches the chain end before the first is taken
`default_nettype none

module countdown_timer_bank #(
    parameter int MS_TIMERS    = 16,
    parameter int SEC_TIMERS   = 16,
    parameter int DELAY_TIMERS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // timer_index[3:0], load_value[19:4], zero pad
    input  wire logic [3:0]  s_tuser,   // action[1:0], bank[3:2]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // read_value[15:0]
    // ticks_per_second write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    // chain is as long as the largest bank
    localparam int CHAIN_LEN =
        (MS_TIMERS > SEC_TIMERS)
            ? ((MS_TIMERS > DELAY_TIMERS) ? MS_TIMERS : DELAY_TIMERS)
            : ((SEC_TIMERS > DELAY_TIMERS) ? SEC_TIMERS : DELAY_TIMERS);

    logic [cdtb_pkg::TPS_W-1:0] tps_reg;
    logic [cdtb_pkg::TPS_W-1:0] limit;

    cdtb_pkg::cmd_t             head_reg, head_next;
    cdtb_pkg::cmd_t             chain [CHAIN_LEN+1];
    cdtb_pkg::cmd_t             tail;

    logic                       busy_reg, busy_next;
    logic                       out_valid_reg, out_valid_next;
    logic [cdtb_pkg::VAL_W-1:0] out_data_reg;

    logic                       accept;
    logic                       advance;
    logic [CHAIN_LEN:0]         vld;

    // config register, always ready; values above range act as the maximum
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= cdtb_pkg::TPS_RESET;
        else if (cfg_valid && cfg_ready)
            tps_reg <= cfg_data;
    end

    assign limit = (tps_reg > cdtb_pkg::TPS_MAX) ? cdtb_pkg::TPS_MAX : tps_reg;

    // one item in flight at a time
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    assign tail    = chain[CHAIN_LEN];
    // hold the whole chain only when the end cell has a result and nowhere to put it
    assign advance = !(tail.valid && out_valid_reg && !m_tready);

    always_comb
    begin
        head_next = head_reg;
        if (accept)
        begin
            head_next.valid  = 1'b1;
            head_next.action = s_tuser[1:0];
            head_next.bank   = s_tuser[3:2];
            head_next.idx    = s_tdata[3:0];
            head_next.load   = s_tdata[19:4];
            head_next.rdata  = '0;
        end
        else if (advance)
            head_next.valid = 1'b0;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tail.valid && advance)
            busy_next = 1'b0;
        if (tail.valid && advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (tail.valid && advance)
            out_data_reg <= tail.rdata;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // cell chain: cell k holds timer k of each bank that is that large
    assign chain[0] = head_reg;

    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_cell
        cdtb_cell #(
            .CELL_IDX  (k),
            .HAS_MS    (k < MS_TIMERS),
            .HAS_SEC   (k < SEC_TIMERS),
            .HAS_DELAY (k < DELAY_TIMERS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .limit   (limit),
            .cmd_in  (chain[k]),
            .cmd_out (chain[k+1])
        );
    end

    for (genvar k = 0; k <= CHAIN_LEN; k++)
    begin : g_vld
        assign vld[k] = chain[k].valid;
    end

`ifndef SYNTHESIS
    // never more than one item inside the chain
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vld))
        else $error("more than one item in the cell chain");

    // busy flag tracks the chain contents
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg == (|vld))
        else $error("busy flag out of step with the chain");

    // an accepted item closes the input until its result leaves the chain
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a result never drops out while the output register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && out_valid_reg && !m_tready) |=> tail.valid)
        else $error("chain end lost a result under stall");
`endif

endmodule

`default_nettype wire

[tb/sv/countdown_timer_bank_tb.sv]
`default_nettype none

module countdown_timer_bank_tb;

    // codes outside the defined ranges, kept on purpose in the stimulus
    localparam logic [cdtb_pkg::ACT_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [cdtb_pkg::BANK_W-1:0] BANK_NONE  = 2'd3;

    localparam int TIMERS       = 16;
    localparam int DRAIN_CYCLES = 40;      // margin beyond the chain walk
    localparam int PHASES       = 10;
    localparam int RANDOM_OPS   = 133;     // per phase

    typedef struct packed {
        logic [cdtb_pkg::ACT_W-1:0]  action;
        logic [cdtb_pkg::BANK_W-1:0] bank;
        logic [cdtb_pkg::IDX_W-1:0]  idx;
        logic [cdtb_pkg::VAL_W-1:0]  load;
    } timer_op_t;

    // mirror of the timer bank; expects one read_value item per accepted input item
    class timer_scoreboard;
        logic [cdtb_pkg::VAL_W-1:0] ms_cnt[TIMERS];
        logic [cdtb_pkg::VAL_W-1:0] sec_cnt[TIMERS];
        logic [cdtb_pkg::SUB_W-1:0] sec_sub[TIMERS];
        logic [cdtb_pkg::VAL_W-1:0] dly_cnt[TIMERS];
        logic [cdtb_pkg::TPS_W-1:0] rate;
        logic [cdtb_pkg::VAL_W-1:0] expected_reads[$];
        int                         errors;

        function new();
            for (int i = 0; i < TIMERS; i++)
            begin
                ms_cnt[i]  = '0;
                sec_cnt[i] = '0;
                sec_sub[i] = '0;
                dly_cnt[i] = '0;
            end
            rate   = cdtb_pkg::TPS_RESET;
            errors = 0;
        endfunction

        function void set_rate(logic [cdtb_pkg::TPS_W-1:0] v);
            rate = v;
        endfunction

        function int pending();
            return expected_reads.size();
        endfunction

        function void advance_one_ms();
            logic [cdtb_pkg::TPS_W-1:0] limit;
            int                         nxt;
            limit = (rate > cdtb_pkg::TPS_MAX) ? cdtb_pkg::TPS_MAX : rate;
            for (int i = 0; i < TIMERS; i++)
            begin
                if (ms_cnt[i] != 0)
                    ms_cnt[i] = ms_cnt[i] - 1'b1;
                if (dly_cnt[i] != 0)
                    dly_cnt[i] = dly_cnt[i] - 1'b1;
            end
            // second timer zero never runs
            for (int i = 1; i < TIMERS; i++)
            begin
                if (sec_cnt[i] != 0)
                begin
                    nxt = int'(sec_sub[i]) + 1;
                    if (nxt >= int'(limit))
                    begin
                        sec_sub[i] = '0;
                        sec_cnt[i] = sec_cnt[i] - 1'b1;
                    end
                    else
                        sec_sub[i] = nxt[cdtb_pkg::SUB_W-1:0];
                end
            end
        endfunction

        function void note_item(timer_op_t op);
            logic [cdtb_pkg::VAL_W-1:0] rd;
            rd = '0;
            if (op.action == cdtb_pkg::ACT_TICK)
                advance_one_ms();
            else if (op.action == cdtb_pkg::ACT_WRITE)
            begin
                case (op.bank)
                    cdtb_pkg::BANK_MS:    ms_cnt[op.idx]  = op.load;
                    cdtb_pkg::BANK_SEC:   sec_cnt[op.idx] = op.load;   // sub-counter untouched
                    cdtb_pkg::BANK_DELAY: dly_cnt[op.idx] = op.load;
                    default:              ;
                endcase
            end
            else if (op.action == cdtb_pkg::ACT_READ)
            begin
                case (op.bank)
                    cdtb_pkg::BANK_MS:    rd = ms_cnt[op.idx];
                    cdtb_pkg::BANK_SEC:   rd = sec_cnt[op.idx];
                    cdtb_pkg::BANK_DELAY: rd = dly_cnt[op.idx];
                    default:              rd = '0;
                endcase
            end
            expected_reads.push_back(rd);
        endfunction

        function void check_read(logic [cdtb_pkg::VAL_W-1:0] got);
            logic [cdtb_pkg::VAL_W-1:0] want;
            if (expected_reads.size() == 0)
            begin
                $error("read_value: no item expected, got %0d", got);
                errors++;
            end
            else
            begin
                want = expected_reads.pop_front();
                if (got !== want)
                begin
                    $error("read_value: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    // every input known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // timer_index[3:0], load_value[19:4], zero pad
    logic [3:0]  s_tuser   = '0;   // action[1:0], bank[3:2]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // read_value[15:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data  = '0;   // ticks_per_second

    timer_scoreboard sb;
    int              tx_gap_max = 12;
    int              rx_gap_max = 12;

    always #2 clk = ~clk;

    countdown_timer_bank dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // present one item after a random gap, return at the edge that takes it
    // valid only drops when a gap follows, so it never toggles within one step
    task automatic send_op(timer_op_t op);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {op.bank, op.action};
        s_tdata  <= {4'b0, op.load, op.idx};
        do @(posedge clk); while (!s_tready);
        sb.note_item(op);
    endtask

    // result side: random stall per item, values sampled as they were before the edge
    task automatic collect_reads();
        int stall;
        forever
        begin
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_read(m_tdata);
        end
    endtask

    // ticks_per_second is only written while nothing is in flight
    task automatic write_rate(logic [cdtb_pkg::TPS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_rate(v);
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic timer_op_t make_op(logic [cdtb_pkg::ACT_W-1:0]  a,
                                          logic [cdtb_pkg::BANK_W-1:0] b,
                                          logic [cdtb_pkg::IDX_W-1:0]  i,
                                          logic [cdtb_pkg::VAL_W-1:0]  v);
        timer_op_t op;
        op.action = a;
        op.bank   = b;
        op.idx    = i;
        op.load   = v;
        return op;
    endfunction

    // ticks and small loads dominate so timers actually run out and sit at zero
    function automatic timer_op_t random_op();
        timer_op_t op;
        int        r;
        r = $urandom_range(0, 99);
        if (r < 40)
            op.action = cdtb_pkg::ACT_TICK;
        else if (r < 65)
            op.action = cdtb_pkg::ACT_WRITE;
        else if (r < 95)
            op.action = cdtb_pkg::ACT_READ;
        else
            op.action = ACT_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 32)
            op.bank = cdtb_pkg::BANK_MS;
        else if (r < 64)
            op.bank = cdtb_pkg::BANK_SEC;
        else if (r < 95)
            op.bank = cdtb_pkg::BANK_DELAY;
        else
            op.bank = BANK_NONE;
        op.idx = cdtb_pkg::IDX_W'($urandom_range(0, TIMERS - 1));
        r = $urandom_range(0, 99);
        if (r < 55)
            op.load = cdtb_pkg::VAL_W'($urandom_range(0, 6));
        else if (r < 70)
        begin
            case ($urandom_range(0, 2))
                0:       op.load = 16'hFFFF;
                1:       op.load = 16'h8000;
                default: op.load = 16'h0001;
            endcase
        end
        else
            op.load = cdtb_pkg::VAL_W'($urandom_range(0, 65535));
        return op;
    endfunction

    initial
    begin
        timer_op_t                  directed[$];
        logic [cdtb_pkg::TPS_W-1:0] rates[PHASES];
        int                         tx_max[PHASES];
        int                         rx_max[PHASES];

        // phase 0 runs at the reset rate; zero, 2047 and 1024 cover the threshold edges
        rates  = '{11'd1000, 11'd0, 11'd1, 11'd2047, 11'd3, 11'd1024, 11'd7, 11'd1,
                   11'd2, 11'd5};
        // two phases with no idling on either side
        tx_max = '{12, 12, 12, 12, 0, 12, 12, 12, 0, 12};
        rx_max = '{12, 12, 12, 12, 0, 12, 12, 12, 0, 12};

        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            collect_reads();
        join_none

        // extremes, every action, the unused codes, second timer zero
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_MS,    4'd0,  16'hFFFF));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_MS,    4'd15, 16'h0001));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_SEC,   4'd0,  16'd5));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_SEC,   4'd15, 16'd2));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_SEC,   4'd1,  16'd0));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_DELAY, 4'd0,  16'h0001));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_DELAY, 4'd15, 16'hFFFF));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, BANK_NONE,            4'd7,  16'hAAAA));
        directed.push_back(make_op(ACT_UNUSED,          cdtb_pkg::BANK_MS,    4'd0,  16'h5555));
        directed.push_back(make_op(cdtb_pkg::ACT_TICK,  cdtb_pkg::BANK_MS,    4'd0,  16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_TICK,  BANK_NONE,            4'd15, 16'hFFFF));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_MS,    4'd0,  16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_MS,    4'd15, 16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_SEC,   4'd0,  16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_SEC,   4'd15, 16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_SEC,   4'd1,  16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_DELAY, 4'd0,  16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_DELAY, 4'd15, 16'h0000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  BANK_NONE,            4'd7,  16'hFFFF));
        directed.push_back(make_op(ACT_UNUSED,          cdtb_pkg::BANK_SEC,   4'd15, 16'hFFFF));
        directed.push_back(make_op(cdtb_pkg::ACT_WRITE, cdtb_pkg::BANK_MS,    4'd9,  16'h8000));
        directed.push_back(make_op(cdtb_pkg::ACT_READ,  cdtb_pkg::BANK_MS,    4'd9,  16'h0000));
        foreach (directed[k])
            send_op(directed[k]);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                // bank idle before the rate changes
                s_tvalid <= 1'b0;
                drain();
                write_rate(rates[p]);
            end
            tx_gap_max = tx_max[p];
            rx_gap_max = rx_max[p];
            for (int n = 0; n < RANDOM_OPS; n++)
                send_op(random_op());
        end
        s_tvalid <= 1'b0;
        drain();

        if (sb.errors == 0)
            $display("countdown_timer_bank_tb OK");
        else
            $display("countdown_timer_bank_tb NOT OK");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("countdown_timer_bank_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
